/* rtl/kws_pkg.sv */
// Shared types and constants for the keyed window statistics table.
// No dependencies.
package kws_pkg;

	localparam int SECTIONS   = 64;
	localparam int SLOT_W     = $clog2(SECTIONS);
	localparam int USED_W     = SLOT_W + 1;
	localparam int HIST_DEPTH = 256;
	localparam int POS_W      = $clog2(HIST_DEPTH);
	localparam int FILL_W     = POS_W + 1;
	localparam int KEY_W      = 32;
	localparam int SAMPLE_W   = 24;
	localparam int SUM_W      = 32;
	localparam int CNT_W      = 32;
	localparam int STATUS_W   = 3;
	localparam int HADDR_W    = SLOT_W + POS_W;

	typedef enum logic [STATUS_W-1:0] {
		ST_EXISTING = 3'd0,
		ST_CREATED  = 3'd1,
		ST_FULL     = 3'd2,
		ST_PAUSED   = 3'd3,
		ST_CLEARED  = 3'd4
	} status_t;

	typedef struct packed {
		logic [POS_W-1:0]    pos;
		logic [FILL_W-1:0]   fill;
		logic [SUM_W-1:0]    sum;
		logic [SAMPLE_W-1:0] last;
		logic [SAMPLE_W-1:0] peak;
		logic [CNT_W-1:0]    count;
	} stats_t;

	localparam int STATS_W = $bits(stats_t);

endpackage

/* rtl/kws_ram.sv */
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module kws_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* rtl/kws_div.sv */
// Restoring divider, one quotient bit per cycle: window sum over fill count.
// Depends on kws_pkg.
module kws_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [kws_pkg::SUM_W-1:0]   dividend,
	input  logic [kws_pkg::FILL_W-1:0]  divisor,
	output logic                        done,
	output logic [kws_pkg::SAMPLE_W-1:0] quotient
);
	import kws_pkg::*;

	localparam int CW = $clog2(SUM_W + 1);

	logic              busy_q;
	logic              done_q;
	logic [CW-1:0]     cnt_q;
	logic [SUM_W-1:0]  q_q;
	logic [FILL_W-1:0] rem_q;
	logic [FILL_W-1:0] div_q;
	logic [FILL_W:0]   shifted;
	logic              ge;

	assign shifted = {rem_q, q_q[SUM_W-1]};
	assign ge      = shifted >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(SUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q   <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			q_q   <= {q_q[SUM_W-2:0], ge};
			rem_q <= ge ? FILL_W'(shifted - {1'b0, div_q}) : FILL_W'(shifted);
		end
	end

	assign done     = done_q;
	assign quotient = q_q[SAMPLE_W-1:0];

endmodule

/* rtl/keyed_window_stats_table.sv */
// Keyed window statistics table: per-key history ring, peak, count and window mean.
// Sequence: a clear or paused request goes straight to the result; a full table is
// reported after all 64 slots are scanned; a record runs the linear key scan over the
// used slots, the stat read, history read and update, then the divider and any output stall.
// Throughput: one item at a time; the linear key scan and the bit-serial divider set it.
// Reset: arst_n clears the slot count, the pause bit and all control; memories keep data.
// Depends on kws_pkg, kws_ram, kws_div.
module keyed_window_stats_table (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic                           cfg_wdata,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           mode,
	input  logic [kws_pkg::KEY_W-1:0]      section_key,
	input  logic [kws_pkg::SAMPLE_W-1:0]   sample,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [kws_pkg::STATUS_W-1:0]   status,
	output logic [kws_pkg::SLOT_W-1:0]     slot,
	output logic [kws_pkg::SAMPLE_W-1:0]   last_sample,
	output logic [kws_pkg::SAMPLE_W-1:0]   window_mean,
	output logic [kws_pkg::SAMPLE_W-1:0]   peak,
	output logic [kws_pkg::CNT_W-1:0]      call_count,
	output logic [kws_pkg::FILL_W-1:0]     window_fill
);
	import kws_pkg::*;

	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_SEARCH = 7'b0000010,
		S_STAT   = 7'b0000100,
		S_LOAD   = 7'b0001000,
		S_UPD    = 7'b0010000,
		S_DIV    = 7'b0100000,
		S_DONE   = 7'b1000000
	} state_t;

	state_t              state_q;
	logic                paused_q;
	logic [USED_W-1:0]   used_q;
	logic [SLOT_W-1:0]   idx_q;
	logic [SLOT_W-1:0]   slot_q;
	logic                created_q;
	logic [KEY_W-1:0]    key_q;
	logic [SAMPLE_W-1:0] smp_q;
	stats_t              st_q;
	stats_t              st_sel;
	stats_t              st_new;
	stats_t              stat_rdata;
	logic [KEY_W-1:0]    key_rdata;
	logic [SAMPLE_W-1:0] hist_rdata;
	logic [SLOT_W-1:0]   key_raddr;
	logic                in_xfer;
	logic                div_done;
	logic [SAMPLE_W-1:0] quot;
	logic [USED_W-1:0]   next_idx;
	logic                res_busy;

	status_t             res_status_q;
	logic [SLOT_W-1:0]   res_slot_q;
	stats_t              res_st_q;

	assign in_stall = (state_q != S_IDLE);
	assign in_xfer  = in_valid && !in_stall;
	assign next_idx = {1'b0, idx_q} + 1'b1;
	assign res_busy = out_valid && out_stall;

	always_comb begin
		key_raddr = '0;
		if (state_q == S_SEARCH) begin
			key_raddr = next_idx[SLOT_W-1:0];
		end
	end

	assign st_sel = created_q ? '0 : stat_rdata;

	always_comb begin
		st_new      = st_q;
		st_new.pos  = st_q.pos + 1'b1;
		if (st_q.fill[FILL_W-1]) begin
			st_new.sum = st_q.sum - SUM_W'(hist_rdata) + SUM_W'(smp_q);
		end else begin
			st_new.fill = st_q.fill + 1'b1;
			st_new.sum  = st_q.sum + SUM_W'(smp_q);
		end
		st_new.last = smp_q;
		if (st_q.count != '1) begin
			st_new.count = st_q.count + 1'b1;
		end
		if (smp_q > st_q.peak) begin
			st_new.peak = smp_q;
		end
	end

	kws_ram #(.WIDTH(KEY_W), .DEPTH(SECTIONS)) u_key_ram (
		.clk   (clk),
		.we    (state_q == S_STAT && created_q),
		.waddr (slot_q),
		.wdata (key_q),
		.raddr (key_raddr),
		.rdata (key_rdata)
	);

	kws_ram #(.WIDTH(STATS_W), .DEPTH(SECTIONS)) u_stat_ram (
		.clk   (clk),
		.we    (state_q == S_UPD),
		.waddr (slot_q),
		.wdata (st_new),
		.raddr (slot_q),
		.rdata (stat_rdata)
	);

	kws_ram #(.WIDTH(SAMPLE_W), .DEPTH(SECTIONS * HIST_DEPTH)) u_hist_ram (
		.clk   (clk),
		.we    (state_q == S_UPD),
		.waddr ({slot_q, st_q.pos}),
		.wdata (smp_q),
		.raddr ({slot_q, st_sel.pos}),
		.rdata (hist_rdata)
	);

	kws_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (state_q == S_UPD),
		.dividend (st_new.sum),
		.divisor  (st_new.fill),
		.done     (div_done),
		.quotient (quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			paused_q <= 1'b0;
		end else if (cfg_we) begin
			paused_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			used_q    <= '0;
			out_valid <= 1'b0;
		end else begin
			if (state_q == S_DONE && !res_busy) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						if (mode) begin
							used_q  <= '0;
							state_q <= S_DONE;
						end else if (paused_q) begin
							state_q <= S_DONE;
						end else if (used_q == '0) begin
							used_q  <= used_q + 1'b1;
							state_q <= S_STAT;
						end else begin
							state_q <= S_SEARCH;
						end
					end
				end
				S_SEARCH: begin
					if (key_rdata == key_q) begin
						state_q <= S_STAT;
					end else if (next_idx < used_q) begin
						state_q <= S_SEARCH;
					end else if (used_q[USED_W-1]) begin
						state_q <= S_DONE;
					end else begin
						used_q  <= used_q + 1'b1;
						state_q <= S_STAT;
					end
				end
				S_STAT:   state_q <= S_LOAD;
				S_LOAD:   state_q <= S_UPD;
				S_UPD:    state_q <= S_DIV;
				S_DIV: begin
					if (div_done) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (!res_busy) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				idx_q     <= '0;
				key_q     <= section_key;
				smp_q     <= sample;
				slot_q    <= '0;
				created_q <= 1'b1;
				res_slot_q <= '0;
				res_st_q   <= '0;
				res_status_q <= mode ? ST_CLEARED : (paused_q ? ST_PAUSED : ST_CREATED);
			end
			S_SEARCH: begin
				idx_q <= next_idx[SLOT_W-1:0];
				if (key_rdata == key_q) begin
					slot_q       <= idx_q;
					created_q    <= 1'b0;
					res_status_q <= ST_EXISTING;
				end else if (!(next_idx < used_q)) begin
					// not found: open the next slot or drop when full
					slot_q       <= used_q[SLOT_W-1:0];
					res_status_q <= used_q[USED_W-1] ? ST_FULL : ST_CREATED;
				end
			end
			S_LOAD: begin
				st_q <= st_sel;
			end
			S_UPD: begin
				res_st_q   <= st_new;
				res_slot_q <= slot_q;
			end
			S_DIV: begin
				if (div_done) begin
					res_st_q.sum <= SUM_W'(quot);
				end
			end
			S_DONE: begin
				if (!res_busy) begin
					status      <= res_status_q;
					slot        <= res_slot_q;
					last_sample <= res_st_q.last;
					window_mean <= res_st_q.sum[SAMPLE_W-1:0];
					peak        <= res_st_q.peak;
					call_count  <= res_st_q.count;
					window_fill <= res_st_q.fill;
				end
			end
			default: begin
			end
		endcase
	end

`ifndef SYNTH
	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("state register not one-hot");

	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= USED_W'(SECTIONS))
		else $error("slot count beyond table size");

	a_div_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == S_DIV)
		else $error("divider finished outside the divide state");

	a_fill_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_UPD |-> st_new.fill != '0)
		else $error("divide by zero fill count");
`endif

endmodule
